// ----- rtl/chzrd_pkg.sv -----
// Shared types, widths and helpers for the canonical Huffman zero-run decoder.
package chzrd_pkg;

    localparam int CFG_W        = 56;   // packed per-length code counts
    localparam int APB_DW       = 64;
    localparam int APB_AW       = 4;
    localparam int CNT_W        = 8;    // one per-length count
    localparam int CODE_W       = 14;   // longest code
    localparam int LEN_W        = 4;
    localparam int FIRST_W      = 23;   // first code of a length, bounded for counts <= 255
    localparam int BASE_W       = 12;   // symbol index of first code, sum of 13 counts
    localparam int SYM_W        = 8;
    localparam int RUN_W        = 14;
    localparam int MAX_LEN      = 14;
    localparam int MAX_SYMBOLS  = 256;
    localparam int TILE_SYMBOLS = 16383;
    localparam int RUN_MAX      = 16383;

    // Register byte addresses, selected by paddr[3]
    localparam logic REG_COUNTS_SHORT = 1'b0;
    localparam logic REG_COUNTS_LONG  = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] counts_short;
        logic [CFG_W-1:0] counts_long;
    } cfg_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic [RUN_W-1:0] repeat_res;
        logic             tile_done;
        logic             code_error;
    } res_t;

    // Number of codes of a given length; zero outside 1..14
    function automatic logic [CNT_W-1:0] count_of(
        input logic [CFG_W-1:0] cs,
        input logic [CFG_W-1:0] cl,
        input logic [LEN_W-1:0] len
    );
        logic [CNT_W-1:0] c;
        c = '0;
        case (len)
            4'd1:    c = cs[7:0];
            4'd2:    c = cs[15:8];
            4'd3:    c = cs[23:16];
            4'd4:    c = cs[31:24];
            4'd5:    c = cs[39:32];
            4'd6:    c = cs[47:40];
            4'd7:    c = cs[55:48];
            4'd8:    c = cl[7:0];
            4'd9:    c = cl[15:8];
            4'd10:   c = cl[23:16];
            4'd11:   c = cl[31:24];
            4'd12:   c = cl[39:32];
            4'd13:   c = cl[47:40];
            4'd14:   c = cl[55:48];
            default: c = '0;
        endcase
        return c;
    endfunction

    // Clamp a grown run total to the run ceiling
    function automatic logic [RUN_W-1:0] sat_run(input logic [RUN_W:0] s);
        logic [RUN_W-1:0] r;
        r = (s > (RUN_W+1)'(RUN_MAX)) ? RUN_W'(RUN_MAX) : s[RUN_W-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/canonical_huffman_zero_run_decoder_top.sv -----
// Top level of the canonical Huffman decoder with zero-run escape.
//
// Input stream: one compressed bit per beat (s_tdata[0]); s_tuser[0] marks
// the first bit of a tile and restarts the decoder and the tile count.
// Output stream: one beat per decoded symbol or zero run: symbol and repeat
// count in m_tdata, m_tlast set when the tile size has been reached, m_tuser
// set when no code matched within 14 bits.
// Configuration: APB registers counts_short (0x0) and counts_long (0x8) hold
// the 8-bit code counts per length; write them while the stream is quiet and
// no code is partly received.
// Throughput: one input bit per cycle while s_tready is high. The code match,
// run-length field and tile count for a bit are settled in the cycle the bit is
// taken; the first code and base index per length advance incrementally per bit.
// Latency: a result appears on m_tvalid the cycle after its final bit.
// A single output register holds the result; while the receiver stalls it
// holds, and s_tready falls only while that register is full and not taken.
// Reset clears the counts, the decoder state and the output valid flag; the result payload is not reset.
// After the tile is done, bits are consumed without results until tile start.
module canonical_huffman_zero_run_decoder_top (
    input  logic                         clk,
    input  logic                         rst_n,
    // APB configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [chzrd_pkg::APB_AW-1:0] paddr,
    input  logic [chzrd_pkg::APB_DW-1:0] pwdata,
    output logic [chzrd_pkg::APB_DW-1:0] prdata,
    output logic                         pready,
    // Compressed bit stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [0] code_bit, [7:1] zero
    input  logic                         s_tuser,   // [0] tile_start
    // Decoded stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [23:0]                  m_tdata,   // [7:0] symbol, [21:8] repeat_res, [23:22] zero
    output logic                         m_tlast,   // tile_done
    output logic                         m_tuser    // [0] code_error
);
    import chzrd_pkg::*;

    cfg_t cfg;
    res_t res;
    res_t res_q;
    logic res_valid;
    logic bit_accept;
    logic free;

    chzrd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_tready   = free;
    assign bit_accept = s_tvalid & s_tready;

    chzrd_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .bit_accept (bit_accept),
        .code_bit   (s_tdata[0]),
        .tile_start (s_tuser),
        .cfg        (cfg),
        .res_valid  (res_valid),
        .res        (res)
    );

    chzrd_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (bit_accept & res_valid),
        .res      (res),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .res_q    (res_q),
        .free     (free)
    );

    // Pack result beat
    assign m_tdata = {2'b00, res_q.repeat_res, res_q.symbol};
    assign m_tlast = res_q.tile_done;
    assign m_tuser = res_q.code_error;

endmodule

// ----- rtl/chzrd_cfg.sv -----
// APB register file holding the per-length code counts.
module chzrd_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [chzrd_pkg::APB_AW-1:0] paddr,
    input  logic [chzrd_pkg::APB_DW-1:0] pwdata,
    output logic [chzrd_pkg::APB_DW-1:0] prdata,
    output logic                         pready,
    output chzrd_pkg::cfg_t              cfg
);
    import chzrd_pkg::*;

    logic [CFG_W-1:0] counts_short_reg;
    logic [CFG_W-1:0] counts_long_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    // Write the selected count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counts_short_reg <= '0;
            counts_long_reg  <= '0;
        end
        else if (wr_en)
        begin
            if (paddr[3] == REG_COUNTS_LONG)
                counts_long_reg <= pwdata[CFG_W-1:0];
            else
                counts_short_reg <= pwdata[CFG_W-1:0];
        end
    end

    // Read back, zero-extended
    assign prdata = (paddr[3] == REG_COUNTS_LONG)
                  ? {{(APB_DW-CFG_W){1'b0}}, counts_long_reg}
                  : {{(APB_DW-CFG_W){1'b0}}, counts_short_reg};

    assign cfg.counts_short = counts_short_reg;
    assign cfg.counts_long  = counts_long_reg;

endmodule

// ----- rtl/chzrd_decode.sv -----
// Bit-serial decode state: canonical code match, run-length escape, tile count.
module chzrd_decode (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            bit_accept,
    input  logic            code_bit,
    input  logic            tile_start,
    input  chzrd_pkg::cfg_t cfg,
    output logic            res_valid,
    output chzrd_pkg::res_t res
);
    import chzrd_pkg::*;

    typedef enum logic [2:0] {
        PH_CODE,
        PH_RUN1,
        PH_RUN2,
        PH_SHORTA,
        PH_SHORTB,
        PH_ZEROS,
        PH_FIVE,
        PH_DONE
    } phase_t;

    phase_t             phase_reg,   phase_next;
    logic [CODE_W-1:0]  value_reg,   value_next;
    logic [LEN_W-1:0]   len_reg,     len_next;
    logic [FIRST_W-1:0] first_reg,   first_next;
    logic [BASE_W-1:0]  base_reg,    base_next;
    logic [RUN_W-1:0]   run_reg,     run_next;
    logic [4:0]         fbits_reg,   fbits_next;
    logic [2:0]         fcount_reg,  fcount_next;
    logic [RUN_W-1:0]   written_reg, written_next;

    // State as seen after an optional tile restart
    phase_t             ph;
    logic [CODE_W-1:0]  val;
    logic [LEN_W-1:0]   len;
    logic [FIRST_W-1:0] first;
    logic [BASE_W-1:0]  base;
    logic [RUN_W-1:0]   run;
    logic [4:0]         fbits;
    logic [2:0]         fcount;
    logic [RUN_W-1:0]   written;

    // Code match datapath
    logic [CNT_W-1:0]   n_prev;
    logic [CNT_W-1:0]   n_cur;
    logic [LEN_W-1:0]   len_new;
    logic [CODE_W-1:0]  val_new;
    logic [FIRST_W-1:0] first_new;
    logic [BASE_W-1:0]  base_new;
    logic [FIRST_W-1:0] diff;
    logic [BASE_W:0]    sym_full;
    logic               hit;

    logic [4:0]         fbits_new;
    logic [2:0]         fcount_new;
    logic [RUN_W:0]     total;
    logic               do_emit;
    logic               do_err;
    logic               done;
    logic [SYM_W-1:0]   emit_sym;
    logic [RUN_W-1:0]   emit_rep;

    always_comb
    begin
        // Restart decoder and tile count on tile start
        ph      = phase_reg;
        val     = value_reg;
        len     = len_reg;
        first   = first_reg;
        base    = base_reg;
        run     = run_reg;
        fbits   = fbits_reg;
        fcount  = fcount_reg;
        written = written_reg;
        if (tile_start)
        begin
            ph      = PH_CODE;
            val     = '0;
            len     = '0;
            first   = '0;
            base    = '0;
            run     = '0;
            fbits   = '0;
            fcount  = '0;
            written = '0;
        end

        // Advance first code and base index by one length
        n_prev    = count_of(cfg.counts_short, cfg.counts_long, len);
        len_new   = len + 4'd1;
        n_cur     = count_of(cfg.counts_short, cfg.counts_long, len_new);
        first_new = (first + FIRST_W'(n_prev)) << 1;
        base_new  = base + BASE_W'(n_prev);
        val_new   = {val[CODE_W-2:0], code_bit};
        diff      = FIRST_W'(val_new) - first_new;
        sym_full  = {1'b0, base_new} + (BASE_W+1)'(diff[CNT_W-1:0]);
        hit       = (FIRST_W'(val_new) >= first_new)
                  && (diff < FIRST_W'(n_cur))
                  && (sym_full < (BASE_W+1)'(MAX_SYMBOLS));

        fbits_new  = {fbits[3:0], code_bit};
        fcount_new = fcount + 3'd1;

        phase_next   = ph;
        value_next   = val;
        len_next     = len;
        first_next   = first;
        base_next    = base;
        run_next     = run;
        fbits_next   = fbits;
        fcount_next  = fcount;
        written_next = written;
        do_emit      = 1'b0;
        do_err       = 1'b0;
        emit_sym     = '0;
        emit_rep     = '0;

        case (ph)
            PH_CODE:
            begin
                if (hit)
                begin
                    if (sym_full[SYM_W-1:0] != '0)
                    begin
                        do_emit  = 1'b1;
                        emit_sym = sym_full[SYM_W-1:0];
                        emit_rep = RUN_W'(1);
                    end
                    else
                    begin
                        value_next = '0;
                        len_next   = '0;
                        first_next = '0;
                        base_next  = '0;
                        phase_next = PH_RUN1;
                    end
                end
                else if (len_new >= LEN_W'(MAX_LEN))
                begin
                    do_err = 1'b1;
                end
                else
                begin
                    value_next = val_new;
                    len_next   = len_new;
                    first_next = first_new;
                    base_next  = base_new;
                end
            end
            PH_RUN1:
            begin
                if (code_bit)
                begin
                    do_emit  = 1'b1;
                    emit_rep = RUN_W'(1);
                end
                else
                    phase_next = PH_RUN2;
            end
            PH_RUN2:
            begin
                phase_next = code_bit ? PH_SHORTA : PH_ZEROS;
                run_next   = '0;
            end
            PH_SHORTA:
            begin
                fbits_next = {4'd0, code_bit};
                phase_next = PH_SHORTB;
            end
            PH_SHORTB:
            begin
                do_emit  = 1'b1;
                emit_rep = RUN_W'({fbits[0], code_bit}) + RUN_W'(2);
            end
            PH_ZEROS:
            begin
                if (code_bit)
                begin
                    fbits_next  = '0;
                    fcount_next = '0;
                    phase_next  = PH_FIVE;
                end
                else
                    run_next = sat_run({1'b0, run} + (RUN_W+1)'(32));
            end
            PH_FIVE:
            begin
                if (fcount_new >= 3'd5)
                begin
                    do_emit  = 1'b1;
                    emit_rep = sat_run({1'b0, run} + (RUN_W+1)'(fbits_new)
                                       + (RUN_W+1)'(6));
                end
                else
                begin
                    fbits_next  = fbits_new;
                    fcount_next = fcount_new;
                end
            end
            PH_DONE:
            begin
                // Drop bits until the next tile start
            end
            default:
            begin
                phase_next = PH_CODE;
            end
        endcase

        // Count written symbols, saturating at the tile size
        total = {1'b0, written} + {1'b0, emit_rep};
        done  = total >= (RUN_W+1)'(TILE_SYMBOLS);

        if (do_emit || do_err)
        begin
            value_next  = '0;
            len_next    = '0;
            first_next  = '0;
            base_next   = '0;
            run_next    = '0;
            fbits_next  = '0;
            fcount_next = '0;
            phase_next  = PH_CODE;
        end
        if (do_emit)
        begin
            written_next = done ? RUN_W'(TILE_SYMBOLS) : total[RUN_W-1:0];
            if (done)
                phase_next = PH_DONE;
        end

        res_valid      = do_emit | do_err;
        res.symbol     = emit_sym;
        res.repeat_res = emit_rep;
        res.tile_done  = do_emit & done;
        res.code_error = do_err;
    end

    // Hold decoder state; advance on each accepted bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_CODE;
            value_reg   <= '0;
            len_reg     <= '0;
            first_reg   <= '0;
            base_reg    <= '0;
            run_reg     <= '0;
            fbits_reg   <= '0;
            fcount_reg  <= '0;
            written_reg <= '0;
        end
        else if (bit_accept)
        begin
            phase_reg   <= phase_next;
            value_reg   <= value_next;
            len_reg     <= len_next;
            first_reg   <= first_next;
            base_reg    <= base_next;
            run_reg     <= run_next;
            fbits_reg   <= fbits_next;
            fcount_reg  <= fcount_next;
            written_reg <= written_next;
        end
    end

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg < LEN_W'(MAX_LEN))
        else $error("code length reached the longest code without resolving");

    a_done_full: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) |-> (written_reg == RUN_W'(TILE_SYMBOLS)))
        else $error("tile marked done before the tile size was written");

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.code_error) |-> (res.repeat_res == '0 && !res.tile_done))
        else $error("code error result carries a count");

    a_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.code_error) |-> (res.repeat_res != '0))
        else $error("decoded result with zero count");

    a_five_count: assert property (@(posedge clk) disable iff (!rst_n)
        fcount_reg < 3'd5)
        else $error("run field counter overran five bits");
`endif

endmodule

// ----- rtl/chzrd_out.sv -----
// Result register between the decoder and the output stream.
module chzrd_out (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  chzrd_pkg::res_t res,
    input  logic            m_tready,
    output logic            m_tvalid,
    output chzrd_pkg::res_t res_q,
    output logic            free
);
    import chzrd_pkg::*;

    logic valid_reg, valid_next;
    res_t data_reg;

    // Slot can take a new result when empty or being drained this cycle
    assign free       = !valid_reg || m_tready;
    assign valid_next = load | (valid_reg & !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture result payload
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign m_tvalid = valid_reg;
    assign res_q    = data_reg;

endmodule
